[design/gasf_pkg.sv]
`default_nettype none

package gasf_pkg;

    localparam int MAX_QUERY_DEF   = 256;
    localparam int MAX_SUBJECT_DEF = 4096;
    localparam int ROW_W_DEF       = $clog2(MAX_QUERY_DEF + 1);
    localparam int COL_W_DEF       = $clog2(MAX_SUBJECT_DEF + 1);

    localparam int SYM_W    = 8;
    localparam int SCORE_W  = 18;
    localparam int WEIGHT_W = 5;

    localparam int NUM_REGS   = 3;
    localparam int APB_ADDR_W = $clog2(4 * NUM_REGS);
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MATCH    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MISMATCH = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_GAP      = REG_IDX_W'(2);

    localparam logic MODE_QUERY   = 1'b0;
    localparam logic MODE_SUBJECT = 1'b1;

    typedef logic signed [SCORE_W-1:0]  score_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef struct packed {
        weight_t match_w;
        weight_t mismatch_w;
        weight_t gap_w;
    } gasf_cfg_t;

    // Control and score part of the token that walks down the row of cells.
    typedef struct packed {
        logic              vld;
        logic              restart;
        logic              cand_vld;
        logic [SYM_W-1:0]  sym;
        score_t            up;
        score_t            diag;
        score_t            cand_val;
        score_t            best_val;
    } gasf_tok_t;

    function automatic score_t sat_add(score_t a, weight_t b);
        logic signed [SCORE_W:0] s;
        s = (SCORE_W + 1)'(a) + (SCORE_W + 1)'(b);
        if (s > (SCORE_W + 1)'(SCORE_MAX))
            return SCORE_MAX;
        else if (s < (SCORE_W + 1)'(SCORE_MIN))
            return SCORE_MIN;
        else
            return SCORE_W'(s);
    endfunction

endpackage

`default_nettype wire

[design/gasf_sym_if.sv]
`default_nettype none

interface gasf_sym_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [gasf_pkg::SYM_W-1:0]   symbol;
    logic                         last;

    modport source (output valid, mode, symbol, last, input ready);
    modport sink (input valid, mode, symbol, last, output ready);
endinterface

`default_nettype wire

[design/gasf_res_if.sv]
`default_nettype none

interface gasf_res_if #(
    parameter int BEST_ROW_W = gasf_pkg::ROW_W_DEF,
    parameter int BEST_COL_W = gasf_pkg::COL_W_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [gasf_pkg::SCORE_W-1:0] column_end_score;
    logic signed [gasf_pkg::SCORE_W-1:0] best_score;
    logic [BEST_ROW_W-1:0]               best_row;
    logic [BEST_COL_W-1:0]               best_column;
    logic                                final_res;

    modport source (output valid, column_end_score, best_score, best_row, best_column,
                    final_res, input ready);
    modport sink (input valid, column_end_score, best_score, best_row, best_column,
                  final_res, output ready);
endinterface

`default_nettype wire

[design/gasf_cfg.sv]
`default_nettype none

module gasf_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gasf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [gasf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gasf_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    output gasf_pkg::gasf_cfg_t                      cfg
);
    import gasf_pkg::*;

    gasf_cfg_t            cfg_reg;
    gasf_cfg_t            cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    weight_t              wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_val  = weight_t'(pwdata[WEIGHT_W-1:0]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MATCH:    cfg_next.match_w    = wr_val;
                REG_MISMATCH: cfg_next.mismatch_w = wr_val;
                REG_GAP:      cfg_next.gap_w      = wr_val;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MATCH:    prdata = APB_DATA_W'(cfg_reg.match_w);
            REG_MISMATCH: prdata = APB_DATA_W'(cfg_reg.mismatch_w);
            REG_GAP:      prdata = APB_DATA_W'(cfg_reg.gap_w);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_w    <= weight_t'(1);
            cfg_reg.mismatch_w <= weight_t'(-1);
            cfg_reg.gap_w      <= weight_t'(-2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[design/gasf_cell.sv]
`default_nettype none

module gasf_cell #(
    parameter int ROW_IDX = 1,
    parameter int LEN_W   = gasf_pkg::ROW_W_DEF,
    parameter int CIDX_W  = gasf_pkg::COL_W_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gasf_pkg::gasf_cfg_t           cfg,
    input  wire logic [LEN_W-1:0]              query_len,
    input  wire logic                          q_wr_en,
    input  wire logic [LEN_W-1:0]              q_wr_row,
    input  wire logic [gasf_pkg::SYM_W-1:0]    q_wr_sym,
    input  wire gasf_pkg::gasf_tok_t           tok_in,
    input  wire logic [LEN_W-1:0]              cand_row_in,
    input  wire logic [LEN_W-1:0]              best_row_in,
    input  wire logic [CIDX_W-1:0]             col_in,
    input  wire logic [CIDX_W-1:0]             best_col_in,
    output gasf_pkg::gasf_tok_t                tok_out,
    output logic [LEN_W-1:0]                   cand_row_out,
    output logic [LEN_W-1:0]                   best_row_out,
    output logic [CIDX_W-1:0]                  col_out,
    output logic [CIDX_W-1:0]                  best_col_out
);
    import gasf_pkg::*;

    localparam logic [LEN_W-1:0] MY_ROW  = LEN_W'(ROW_IDX);
    localparam logic [LEN_W-1:0] MY_ADDR = LEN_W'(ROW_IDX - 1);

    logic [SYM_W-1:0]  q_reg;
    logic [SYM_W-1:0]  q_next;
    score_t            score_reg;
    score_t            score_next;
    gasf_tok_t         tok_reg;
    gasf_tok_t         tok_next;
    logic [LEN_W-1:0]  cand_row_reg;
    logic [LEN_W-1:0]  cand_row_next;
    logic [LEN_W-1:0]  best_row_reg;
    logic [LEN_W-1:0]  best_row_next;
    logic [CIDX_W-1:0] col_reg;
    logic [CIDX_W-1:0] best_col_reg;
    logic [CIDX_W-1:0] best_col_next;

    logic    active;
    logic    take;
    weight_t diag_w;
    score_t  d_sum;
    score_t  l_sum;
    score_t  u_sum;
    score_t  dl_max;
    score_t  col_max;
    score_t  cell_new;

    always_comb
    begin
        active = tok_in.vld && (MY_ROW <= query_len);
        diag_w = (q_reg == tok_in.sym) ? cfg.match_w : cfg.mismatch_w;
        d_sum  = sat_add(tok_in.diag, diag_w);
        l_sum  = sat_add(score_reg, cfg.gap_w);
        u_sum  = sat_add(tok_in.up, cfg.gap_w);
        dl_max = (l_sum > d_sum) ? l_sum : d_sum;
        col_max = (u_sum > dl_max) ? u_sum : dl_max;
        // A restart token rebuilds the border column: only the cell above counts.
        cell_new = tok_in.restart ? u_sum : col_max;

        // The previous row's value is folded into the running best one cell later.
        take = tok_in.cand_vld &&
               ((tok_in.cand_val > tok_in.best_val) ||
                ((tok_in.cand_val == tok_in.best_val) && (cand_row_in < best_row_in)));

        tok_next          = tok_in;
        tok_next.up       = active ? cell_new : tok_in.up;
        tok_next.diag     = score_reg;
        tok_next.cand_vld = active;
        tok_next.cand_val = cell_new;
        tok_next.best_val = take ? tok_in.cand_val : tok_in.best_val;
        cand_row_next     = MY_ROW;
        best_row_next     = take ? cand_row_in : best_row_in;
        best_col_next     = take ? col_in : best_col_in;

        score_next = active ? cell_new : score_reg;
        q_next     = (q_wr_en && (q_wr_row == MY_ADDR)) ? q_wr_sym : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        score_reg    <= score_next;
        cand_row_reg <= cand_row_next;
        best_row_reg <= best_row_next;
        col_reg      <= col_in;
        best_col_reg <= best_col_next;
    end

    assign tok_out      = tok_reg;
    assign cand_row_out = cand_row_reg;
    assign best_row_out = best_row_reg;
    assign col_out      = col_reg;
    assign best_col_out = best_col_reg;

endmodule

`default_nettype wire

[design/gasf_ctrl.sv]
`default_nettype none

module gasf_ctrl #(
    parameter int  MAX_QUERY   = gasf_pkg::MAX_QUERY_DEF,
    parameter int  MAX_SUBJECT = gasf_pkg::MAX_SUBJECT_DEF,
    localparam int LEN_W       = $clog2(MAX_QUERY + 1),
    localparam int CIDX_W      = $clog2(MAX_SUBJECT + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gasf_sym_if.sink                           sym_ch,
    gasf_res_if.source                         res_ch,
    input  wire gasf_pkg::gasf_cfg_t           cfg,
    output logic [LEN_W-1:0]                   query_len,
    output logic                               q_wr_en,
    output logic [LEN_W-1:0]                   q_wr_row,
    output logic [gasf_pkg::SYM_W-1:0]         q_wr_sym,
    output gasf_pkg::gasf_tok_t                head_tok,
    output logic [LEN_W-1:0]                   head_cand_row,
    output logic [LEN_W-1:0]                   head_best_row,
    output logic [CIDX_W-1:0]                  head_col,
    output logic [CIDX_W-1:0]                  head_best_col,
    input  wire gasf_pkg::gasf_tok_t           tail_tok,
    input  wire logic [LEN_W-1:0]              tail_cand_row,
    input  wire logic [LEN_W-1:0]              tail_best_row,
    input  wire logic [CIDX_W-1:0]             tail_col,
    input  wire logic [CIDX_W-1:0]             tail_best_col
);
    import gasf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [LEN_W-1:0]  qlen_reg;
    logic [LEN_W-1:0]  qlen_next;
    logic              load_restart_reg;
    logic              load_restart_next;
    logic [CIDX_W-1:0] col_idx_reg;
    logic [CIDX_W-1:0] col_idx_next;
    score_t            corner_reg;
    score_t            corner_next;
    score_t            end_reg;
    score_t            end_next;
    score_t            best_val_reg;
    score_t            best_val_next;
    logic [LEN_W-1:0]  best_row_reg;
    logic [LEN_W-1:0]  best_row_next;
    logic [CIDX_W-1:0] best_col_reg;
    logic [CIDX_W-1:0] best_col_next;
    logic              last_reg;
    logic              last_next;

    gasf_tok_t         head_tok_reg;
    gasf_tok_t         head_tok_next;
    logic [LEN_W-1:0]  head_cand_row_reg;
    logic [LEN_W-1:0]  head_cand_row_next;
    logic [LEN_W-1:0]  head_best_row_reg;
    logic [LEN_W-1:0]  head_best_row_next;
    logic [CIDX_W-1:0] head_col_reg;
    logic [CIDX_W-1:0] head_col_next;
    logic [CIDX_W-1:0] head_best_col_reg;
    logic [CIDX_W-1:0] head_best_col_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    score_t            out_end_reg;
    score_t            out_end_next;
    score_t            out_best_reg;
    score_t            out_best_next;
    logic [LEN_W-1:0]  out_row_reg;
    logic [LEN_W-1:0]  out_row_next;
    logic [CIDX_W-1:0] out_col_reg;
    logic [CIDX_W-1:0] out_col_next;
    logic              out_final_reg;
    logic              out_final_next;

    logic              in_acc;
    logic              out_free;
    logic              launch_rst;
    logic [LEN_W-1:0]  len_base;
    logic              room;
    logic              col_room;
    score_t            corner_new;
    logic [CIDX_W-1:0] col_new;
    logic              take;

    assign sym_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        in_acc     = sym_ch.valid && sym_ch.ready;
        out_free   = !out_valid_reg || res_ch.ready;
        len_base   = load_restart_reg ? '0 : qlen_reg;
        room       = (len_base < LEN_W'(MAX_QUERY));
        col_room   = (col_idx_reg < CIDX_W'(MAX_SUBJECT));
        corner_new = sat_add(corner_reg, cfg.gap_w);
        col_new    = col_idx_reg + 1'b1;
        take       = tail_tok.cand_vld &&
                     ((tail_tok.cand_val > tail_tok.best_val) ||
                      ((tail_tok.cand_val == tail_tok.best_val) &&
                       (tail_cand_row < tail_best_row)));

        state_next         = state_reg;
        qlen_next          = qlen_reg;
        load_restart_next  = load_restart_reg;
        col_idx_next       = col_idx_reg;
        corner_next        = corner_reg;
        end_next           = end_reg;
        best_val_next      = best_val_reg;
        best_row_next      = best_row_reg;
        best_col_next      = best_col_reg;
        last_next          = last_reg;
        head_tok_next      = '0;
        head_cand_row_next = '0;
        head_best_row_next = '0;
        head_col_next      = '0;
        head_best_col_next = '0;
        out_valid_next     = out_valid_reg && !res_ch.ready;
        out_end_next       = out_end_reg;
        out_best_next      = out_best_reg;
        out_row_next       = out_row_reg;
        out_col_next       = out_col_reg;
        out_final_next     = out_final_reg;
        q_wr_en            = 1'b0;
        launch_rst         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (sym_ch.mode == MODE_QUERY)
                    begin
                        // Symbols past the query capacity are dropped but still
                        // rebuild the border column.
                        q_wr_en           = room;
                        qlen_next         = room ? (len_base + 1'b1) : len_base;
                        load_restart_next = sym_ch.last;
                        launch_rst        = 1'b1;
                        state_next        = ST_SWEEP;
                    end
                    else
                    begin
                        last_next = sym_ch.last;
                        if (col_room)
                        begin
                            corner_next            = corner_new;
                            col_idx_next           = col_new;
                            head_tok_next.vld      = 1'b1;
                            head_tok_next.sym      = sym_ch.symbol;
                            head_tok_next.up       = corner_new;
                            head_tok_next.diag     = corner_reg;
                            head_tok_next.cand_vld = 1'b1;
                            head_tok_next.cand_val = corner_new;
                            head_tok_next.best_val = best_val_reg;
                            head_best_row_next     = best_row_reg;
                            head_col_next          = col_new;
                            head_best_col_next     = best_col_reg;
                            state_next             = ST_SWEEP;
                        end
                        else
                        begin
                            // Subject is full: the item repeats the current values.
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (tail_tok.vld)
                begin
                    end_next      = tail_tok.up;
                    best_val_next = take ? tail_tok.cand_val : tail_tok.best_val;
                    best_row_next = take ? tail_cand_row : tail_best_row;
                    best_col_next = take ? tail_col : tail_best_col;
                    state_next    = tail_tok.restart ? ST_IDLE : ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_end_next   = end_reg;
                    out_best_next  = best_val_reg;
                    out_row_next   = best_row_reg;
                    out_col_next   = best_col_reg;
                    out_final_next = last_reg;
                    if (last_reg)
                    begin
                        launch_rst = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (launch_rst)
        begin
            corner_next           = '0;
            col_idx_next          = '0;
            head_tok_next         = '0;
            head_tok_next.vld     = 1'b1;
            head_tok_next.restart = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            qlen_reg         <= '0;
            load_restart_reg <= 1'b1;
            col_idx_reg      <= '0;
            corner_reg       <= '0;
            end_reg          <= '0;
            best_val_reg     <= '0;
            best_row_reg     <= '0;
            best_col_reg     <= '0;
            last_reg         <= 1'b0;
            head_tok_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            qlen_reg         <= qlen_next;
            load_restart_reg <= load_restart_next;
            col_idx_reg      <= col_idx_next;
            corner_reg       <= corner_next;
            end_reg          <= end_next;
            best_val_reg     <= best_val_next;
            best_row_reg     <= best_row_next;
            best_col_reg     <= best_col_next;
            last_reg         <= last_next;
            head_tok_reg     <= head_tok_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_cand_row_reg <= head_cand_row_next;
        head_best_row_reg <= head_best_row_next;
        head_col_reg      <= head_col_next;
        head_best_col_reg <= head_best_col_next;
        out_end_reg       <= out_end_next;
        out_best_reg      <= out_best_next;
        out_row_reg       <= out_row_next;
        out_col_reg       <= out_col_next;
        out_final_reg     <= out_final_next;
    end

    assign query_len     = qlen_reg;
    assign q_wr_row      = len_base;
    assign q_wr_sym      = sym_ch.symbol;
    assign head_tok      = head_tok_reg;
    assign head_cand_row = head_cand_row_reg;
    assign head_best_row = head_best_row_reg;
    assign head_col      = head_col_reg;
    assign head_best_col = head_best_col_reg;

    assign res_ch.valid            = out_valid_reg;
    assign res_ch.column_end_score = out_end_reg;
    assign res_ch.best_score       = out_best_reg;
    assign res_ch.best_row         = out_row_reg;
    assign res_ch.best_column      = out_col_reg;
    assign res_ch.final_res        = out_final_reg;

endmodule

`default_nettype wire

[design/global_alignment_score_fill.sv]
`default_nettype none

// Global alignment score fill with a linear gap. Query symbols (mode 0) are loaded
// first; each one restarts the table by sending a border-rebuild token down the row
// of cells, and the next item is taken only after that token has left the last cell.
// Each subject symbol (mode 1) taken while the subject has room sends one token down
// the row of MAX_QUERY cells, one cell per cycle; the next item is taken only after
// its result has been put in the result register. The token always walks the whole
// row, whatever the length of the loaded query. A subject symbol with last set adds
// one more border-rebuild pass. The result register lets that pass, and the next
// item, proceed while the result waits to be taken. The user must see that score
// registers are written over APB only while the block is idle; the block itself
// does not enforce this.
module global_alignment_score_fill #(
    parameter int MAX_QUERY   = gasf_pkg::MAX_QUERY_DEF,
    parameter int MAX_SUBJECT = gasf_pkg::MAX_SUBJECT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    gasf_sym_if.sink                              sym_ch,
    gasf_res_if.source                            res_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gasf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gasf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gasf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import gasf_pkg::*;

    localparam int LEN_W  = $clog2(MAX_QUERY + 1);
    localparam int CIDX_W = $clog2(MAX_SUBJECT + 1);

    gasf_cfg_t         cfg;
    logic [LEN_W-1:0]  query_len;
    logic              q_wr_en;
    logic [LEN_W-1:0]  q_wr_row;
    logic [SYM_W-1:0]  q_wr_sym;

    gasf_tok_t         tok_link      [0:MAX_QUERY];
    logic [LEN_W-1:0]  cand_row_link [0:MAX_QUERY];
    logic [LEN_W-1:0]  best_row_link [0:MAX_QUERY];
    logic [CIDX_W-1:0] col_link      [0:MAX_QUERY];
    logic [CIDX_W-1:0] best_col_link [0:MAX_QUERY];

    gasf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gasf_ctrl #(
        .MAX_QUERY   (MAX_QUERY),
        .MAX_SUBJECT (MAX_SUBJECT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym_ch        (sym_ch),
        .res_ch        (res_ch),
        .cfg           (cfg),
        .query_len     (query_len),
        .q_wr_en       (q_wr_en),
        .q_wr_row      (q_wr_row),
        .q_wr_sym      (q_wr_sym),
        .head_tok      (tok_link[0]),
        .head_cand_row (cand_row_link[0]),
        .head_best_row (best_row_link[0]),
        .head_col      (col_link[0]),
        .head_best_col (best_col_link[0]),
        .tail_tok      (tok_link[MAX_QUERY]),
        .tail_cand_row (cand_row_link[MAX_QUERY]),
        .tail_best_row (best_row_link[MAX_QUERY]),
        .tail_col      (col_link[MAX_QUERY]),
        .tail_best_col (best_col_link[MAX_QUERY])
    );

    for (genvar g = 1; g <= MAX_QUERY; g++)
    begin : g_cell
        gasf_cell #(
            .ROW_IDX (g),
            .LEN_W   (LEN_W),
            .CIDX_W  (CIDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg          (cfg),
            .query_len    (query_len),
            .q_wr_en      (q_wr_en),
            .q_wr_row     (q_wr_row),
            .q_wr_sym     (q_wr_sym),
            .tok_in       (tok_link[g-1]),
            .cand_row_in  (cand_row_link[g-1]),
            .best_row_in  (best_row_link[g-1]),
            .col_in       (col_link[g-1]),
            .best_col_in  (best_col_link[g-1]),
            .tok_out      (tok_link[g]),
            .cand_row_out (cand_row_link[g]),
            .best_row_out (best_row_link[g]),
            .col_out      (col_link[g]),
            .best_col_out (best_col_link[g])
        );
    end

endmodule

`default_nettype wire

[design/gasf_checker.sv]
`default_nettype none

module gasf_checker #(
    parameter int LEN_W  = gasf_pkg::ROW_W_DEF,
    parameter int CIDX_W = gasf_pkg::COL_W_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              in_mode,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic signed [gasf_pkg::SCORE_W-1:0] out_end,
    input  wire logic signed [gasf_pkg::SCORE_W-1:0] out_best,
    input  wire logic [LEN_W-1:0]                  out_row,
    input  wire logic [CIDX_W-1:0]                 out_col,
    input  wire logic                              out_final
);
    import gasf_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_end) && $stable(out_best) && $stable(out_row) &&
            $stable(out_col) && $stable(out_final))
        else $error("result payload changed while stalled");

    // The bottom cell of every column has been weighed for the best cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_best >= out_end))
        else $error("best score below the column end score");

    // A query item never produces a result of its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_QUERY) |=> !$rose(out_valid))
        else $error("result raised after a query item");

endmodule

bind global_alignment_score_fill gasf_checker #(
    .LEN_W  (LEN_W),
    .CIDX_W (CIDX_W)
) u_gasf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sym_ch.valid),
    .in_ready  (sym_ch.ready),
    .in_mode   (sym_ch.mode),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .out_end   (res_ch.column_end_score),
    .out_best  (res_ch.best_score),
    .out_row   (res_ch.best_row),
    .out_col   (res_ch.best_column),
    .out_final (res_ch.final_res)
);

`default_nettype wire
